/* sv/afoc_pkg.sv */
// afoc_pkg: shared widths, codes and reset constants for the box frustum classifier
// no dependencies
package afoc_pkg;
  localparam int CoordW = 16;
  localparam int ViewW  = 35;
  localparam int CodeW  = 6;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLIP_ON = 3'd0,
    REG_ROW_X   = 3'd1,
    REG_ROW_Y   = 3'd2,
    REG_ROW_Z   = 3'd3,
    REG_NEAR    = 3'd4,
    REG_FAR     = 3'd5,
    REG_TAN_X   = 3'd6,
    REG_TAN_Y   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE = 2'd0,
    VERDICT_INSIDE  = 2'd1,
    VERDICT_PARTIAL = 2'd2
  } verdict_e;

  localparam logic [63:0] RowXReset = 64'd4096;
  localparam logic [63:0] RowYReset = 64'd268435456;
  localparam logic [63:0] RowZReset = 64'd17592186044416;
  localparam logic [14:0] NearReset = 15'd5;
  localparam logic [14:0] FarReset  = 15'd16000;
  localparam logic [15:0] TanReset  = 16'd4096;

  localparam logic [CodeW-1:0] OcNear  = 6'h01;
  localparam logic [CodeW-1:0] OcFar   = 6'h02;
  localparam logic [CodeW-1:0] OcLeft  = 6'h04;
  localparam logic [CodeW-1:0] OcRight = 6'h08;
  localparam logic [CodeW-1:0] OcAbove = 6'h10;
  localparam logic [CodeW-1:0] OcBelow = 6'h20;

  typedef struct packed {
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
    logic [14:0] near_plane;
    logic [14:0] far_plane;
    logic [15:0] tan_x;
    logic [15:0] tan_y;
    logic        clip_on;
  } cfg_t;
endpackage

/* sv/afoc_cfg_regs.sv */
// afoc_cfg_regs: configuration register file with plain write port
// depends on afoc_pkg
module afoc_cfg_regs import afoc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_on    <= 1'b1;
      cfg_q.row_x      <= RowXReset;
      cfg_q.row_y      <= RowYReset;
      cfg_q.row_z      <= RowZReset;
      cfg_q.near_plane <= NearReset;
      cfg_q.far_plane  <= FarReset;
      cfg_q.tan_x      <= TanReset;
      cfg_q.tan_y      <= TanReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CLIP_ON: cfg_q.clip_on    <= cfg_data_i[0];
        REG_ROW_X:   cfg_q.row_x      <= cfg_data_i;
        REG_ROW_Y:   cfg_q.row_y      <= cfg_data_i;
        REG_ROW_Z:   cfg_q.row_z      <= cfg_data_i;
        REG_NEAR:    cfg_q.near_plane <= cfg_data_i[14:0];
        REG_FAR:     cfg_q.far_plane  <= cfg_data_i[14:0];
        REG_TAN_X:   cfg_q.tan_x      <= cfg_data_i[15:0];
        REG_TAN_Y:   cfg_q.tan_y      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

/* sv/afoc_corner.sv */
// afoc_corner: one box corner through the row transform and outcode test, three stages
// stage 1 products, stage 2 row sums, stage 3 side products; outcode is combinational after
// depends on afoc_pkg
module afoc_corner import afoc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  cfg_t                     cfg_i,
  input  logic signed [CoordW-1:0] px_i,
  input  logic signed [CoordW-1:0] py_i,
  input  logic signed [CoordW-1:0] pz_i,
  output logic [CodeW-1:0]         code_o
);
  logic signed [31:0] prod_d [9];
  logic signed [31:0] prod_q [9];
  logic signed [15:0] off_q [3];
  logic signed [ViewW-1:0] v_d [3];
  logic signed [ViewW-1:0] v_q [3];
  logic signed [51:0] sx_d, sy_d, sx_q, sy_q;
  logic signed [ViewW+12-1:0] wx_q, wy_q;
  logic signed [ViewW-1:0] vz3_q;

  function automatic logic signed [15:0] fld(input logic [63:0] r, input int i);
    fld = r[16*i +: 16];
  endfunction

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_d[3*r]   = fld(r == 0 ? cfg_i.row_x : r == 1 ? cfg_i.row_y : cfg_i.row_z, 0) * px_i;
      prod_d[3*r+1] = fld(r == 0 ? cfg_i.row_x : r == 1 ? cfg_i.row_y : cfg_i.row_z, 1) * py_i;
      prod_d[3*r+2] = fld(r == 0 ? cfg_i.row_x : r == 1 ? cfg_i.row_y : cfg_i.row_z, 2) * pz_i;
    end
    for (int r = 0; r < 3; r++) begin
      v_d[r] = ViewW'(prod_q[3*r]) + ViewW'(prod_q[3*r+1]) + ViewW'(prod_q[3*r+2])
             + (ViewW'(off_q[r]) <<< 12);
    end
    // z times tangent, 35x17 signed
    sx_d = 52'(v_q[2]) * $signed({1'b0, cfg_i.tan_x});
    sy_d = 52'(v_q[2]) * $signed({1'b0, cfg_i.tan_y});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      off_q[0] <= fld(cfg_i.row_x, 3);
      off_q[1] <= fld(cfg_i.row_y, 3);
      off_q[2] <= fld(cfg_i.row_z, 3);
      v_q <= v_d;
      sx_q <= sx_d;
      sy_q <= sy_d;
      wx_q <= (ViewW+12)'(v_q[0]) <<< 12;
      wy_q <= (ViewW+12)'(v_q[1]) <<< 12;
      vz3_q <= v_q[2];
    end
  end

  logic signed [ViewW:0] nearv, farv;
  logic signed [52:0] wx, wy, px, py;
  always_comb begin
    nearv = $signed({1'b0, cfg_i.near_plane, 12'd0}) ;
    farv  = $signed({1'b0, cfg_i.far_plane, 12'd0});
    wx = 53'(wx_q);
    wy = 53'(wy_q);
    px = 53'(sx_q);
    py = 53'(sy_q);
    code_o = '0;
    if ((ViewW+1)'(vz3_q) < (nearv >>> 0)) code_o = code_o | OcNear;
    if ((ViewW+1)'(vz3_q) > farv)          code_o = code_o | OcFar;
    if (wx < -px) code_o = code_o | OcLeft;
    if (wx > px)  code_o = code_o | OcRight;
    if (wy < -py) code_o = code_o | OcBelow;
    if (wy > py)  code_o = code_o | OcAbove;
  end
endmodule

/* sv/aabb_frustum_outcode_classify.sv */
// box against view frustum outcode classifier, one transaction per cycle while not stalled
// path from input acceptance to result valid: 3 corner stages, then the output reg
// throughput: one box per cycle while not stalled; eight corner units in parallel, each three register stages
// stalls freeze the whole pipeline when the output register is full and not taken
// reset (async, active low) clears valid bits and loads default config registers
module aabb_frustum_outcode_classify import afoc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] lo_x_i,
  input  logic signed [CoordW-1:0] lo_y_i,
  input  logic signed [CoordW-1:0] lo_z_i,
  input  logic signed [CoordW-1:0] hi_x_i,
  input  logic signed [CoordW-1:0] hi_y_i,
  input  logic signed [CoordW-1:0] hi_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               verdict_o,
  output logic [CodeW-1:0]         all_codes_o,
  output logic [CodeW-1:0]         any_codes_o
);
  cfg_t cfg;
  logic en;
  logic [2:0] vld_q;
  logic [CodeW-1:0] code [8];
  logic [CodeW-1:0] and_c, or_c;
  logic out_vld_q;
  logic [1:0] verdict_q;
  logic [CodeW-1:0] all_q, any_q;

  afoc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  // pipeline advances unless the output register holds an untaken result
  assign en = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  for (genvar k = 0; k < 8; k++) begin : g_corner
    afoc_corner u_corner (
      .clk_i,
      .en_i(en),
      .cfg_i(cfg),
      .px_i(k[2] ? hi_x_i : lo_x_i),
      .py_i(k[1] ? hi_y_i : lo_y_i),
      .pz_i(k[0] ? hi_z_i : lo_z_i),
      .code_o(code[k])
    );
  end

  always_comb begin
    and_c = '1;
    or_c  = '0;
    for (int k = 0; k < 8; k++) begin
      and_c = and_c & code[k];
      or_c  = or_c | code[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[1:0], in_valid_i};
      out_vld_q <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!cfg.clip_on) begin
        verdict_q <= VERDICT_INSIDE;
        all_q <= '0;
        any_q <= '0;
      end else begin
        all_q <= and_c;
        any_q <= or_c;
        if (and_c != '0)     verdict_q <= VERDICT_OUTSIDE;
        else if (or_c != '0) verdict_q <= VERDICT_PARTIAL;
        else                 verdict_q <= VERDICT_INSIDE;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign verdict_o   = verdict_q;
  assign all_codes_o = all_q;
  assign any_codes_o = any_q;
endmodule

/* sv/afoc_checker.sv */
// afoc_checker: port-level assertions for the classifier, bound to the top level
// depends on afoc_pkg
module afoc_checker import afoc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [1:0]       verdict_o,
  input logic [CodeW-1:0] all_codes_o,
  input logic [CodeW-1:0] any_codes_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o))
    else $error("result dropped under stall");
  a_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (all_codes_o & ~any_codes_o) == '0)
    else $error("and code not within or code");
  a_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((all_codes_o != '0) == (verdict_o == VERDICT_OUTSIDE)))
    else $error("verdict disagrees with and code");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> verdict_o != 2'd3)
    else $error("bad verdict");
endmodule

bind aabb_frustum_outcode_classify afoc_checker u_afoc_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .verdict_o, .all_codes_o, .any_codes_o
);
